// ===== design/crm_pkg.sv =====
package crm_pkg;

   localparam int MAX_OUTPUTS_DEF = 8;
   localparam int MAX_INPUTS_DEF  = 8;
   localparam int RESULT_CAP      = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CH_W     = 3;
   localparam int ACT_W    = 4;
   localparam int SAMPLE_W = 32;
   localparam int GAIN_W   = 25;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int ACC_W    = 64;
   localparam int CNT_W    = 32;
   localparam int FRAC_W   = 20;

   typedef enum logic [1:0] {
      KIND_GAIN_WRITE,
      KIND_MIX,
      KIND_SKIP
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CH_W-1:0]     row;
      logic [CH_W-1:0]     col;
      logic [SAMPLE_W-1:0] sample;
      logic [GAIN_W-1:0]   gain;
      logic                frame_end;
   } item_type;

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int eff_rows(input int max_outputs);
      return min_int(min_int(max_outputs, RESULT_CAP), 1 << CH_W);
   endfunction

   function automatic int eff_cols(input int max_inputs);
      return min_int(max_inputs, 1 << CH_W);
   endfunction

endpackage

// ===== design/crm_if.sv =====
interface crm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic [crm_pkg::CH_W-1:0]         in_channel;
   logic [crm_pkg::CH_W-1:0]         out_channel;
   logic signed [crm_pkg::SAMPLE_W-1:0] sample_in;
   logic signed [crm_pkg::GAIN_W-1:0]   gain_value;
   logic                             frame_end;

   modport source (output valid, func, in_channel, out_channel, sample_in, gain_value,
                   frame_end, input ready);
   modport sink   (input valid, func, in_channel, out_channel, sample_in, gain_value,
                   frame_end, output ready);
endinterface

interface crm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [crm_pkg::CH_W-1:0]         out_index;
   logic signed [crm_pkg::SAMPLE_W-1:0] sample_out;
   logic                             was_clipped;
   logic [crm_pkg::CNT_W-1:0]        clip_total;
   logic                             last_of_frame;

   modport source (output valid, out_index, sample_out, was_clipped, clip_total,
                   last_of_frame, input ready);
   modport sink   (input valid, out_index, sample_out, was_clipped, clip_total,
                   last_of_frame, output ready);
endinterface

interface crm_csr_if;
   logic                      valid;
   logic                      ready;
   logic [crm_pkg::ACT_W-1:0] active_outputs;

   modport source (output valid, active_outputs, input ready);
   modport sink   (input valid, active_outputs, output ready);
endinterface

// ===== design/crm_ram.sv =====
module crm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/crm_front.sv =====
module crm_front #(
   parameter int MAX_OUTPUTS = crm_pkg::MAX_OUTPUTS_DEF,
   parameter int MAX_INPUTS  = crm_pkg::MAX_INPUTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   crm_req_if.sink           req_ch,
   output logic              q_valid,
   output crm_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int ROWS  = crm_pkg::eff_rows(MAX_OUTPUTS);
   localparam int COLS  = crm_pkg::eff_cols(MAX_INPUTS);
   localparam int QD    = crm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W = $clog2(QD + 1);

   crm_pkg::item_type q_mem_ff [QD];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   crm_pkg::item_type cls_item;
   logic              keep;
   logic              push;
   logic              row_ok;
   logic              col_ok;

   assign row_ok = int'(req_ch.out_channel) < ROWS;
   assign col_ok = int'(req_ch.in_channel) < COLS;

   always_comb begin
      cls_item.row       = req_ch.out_channel;
      cls_item.col       = req_ch.in_channel;
      cls_item.sample    = req_ch.sample_in;
      cls_item.gain      = req_ch.gain_value;
      cls_item.frame_end = req_ch.frame_end;
      if (req_ch.func) begin
         cls_item.kind = crm_pkg::KIND_GAIN_WRITE;
         keep          = row_ok && col_ok;
      end else if (col_ok) begin
         cls_item.kind = crm_pkg::KIND_MIX;
         keep          = 1'b1;
      end else begin
         // sample on a missing column: only its frame end matters
         cls_item.kind = crm_pkg::KIND_SKIP;
         keep          = req_ch.frame_end;
      end
   end

   assign req_ch.ready = int'(count_ff) < QD;
   assign push         = req_ch.valid && req_ch.ready && keep;
   assign q_valid      = count_ff != '0;
   assign q_item       = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QD - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QD - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

// ===== design/crm_back.sv =====
module crm_back #(
   parameter int MAX_OUTPUTS = crm_pkg::MAX_OUTPUTS_DEF,
   parameter int MAX_INPUTS  = crm_pkg::MAX_INPUTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  crm_pkg::item_type q_item,
   output logic              q_pop,
   crm_csr_if.sink           csr_ch,
   crm_rsp_if.source         rsp_ch
);

   localparam int ROWS  = crm_pkg::eff_rows(MAX_OUTPUTS);
   localparam int COLS  = crm_pkg::eff_cols(MAX_INPUTS);
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CH_W  = crm_pkg::CH_W;
   localparam int SW    = crm_pkg::SAMPLE_W;
   localparam int GW    = crm_pkg::GAIN_W;
   localparam int PW    = crm_pkg::PROD_W;
   localparam int AccW  = crm_pkg::ACC_W;
   localparam int CW    = crm_pkg::CNT_W;
   localparam int FW    = crm_pkg::FRAC_W;
   localparam int RW    = AccW - FW;

   localparam logic [AccW-1:0] ROUND_HALF = AccW'(1) << (FW - 1);
   localparam logic [RW-1:0]   POS_LIM    = RW'(32'h7FFF_FFFF);
   localparam logic [RW-1:0]   NEG_LIM    = RW'(32'h8000_0000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_DRAIN,
      ST_FIN_MAG,
      ST_FIN_OUT
   } state_type;

   state_type         state_ff, state_in;
   crm_pkg::item_type cur_ff, cur_in;
   logic [CH_W-1:0]   o_ff, o_in;
   logic [CH_W-1:0]   last_ff, last_in;
   logic [AccW-1:0]   mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     clip_ff, clip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [SW-1:0]     rsp_sample_ff, rsp_sample_in;
   logic              rsp_clip_ff, rsp_clip_in;
   logic [CW-1:0]     rsp_total_ff, rsp_total_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              prod_v_ff, prod_v_in;
   logic [IDX_W-1:0]  prod_idx_ff, prod_idx_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   logic [AccW-1:0]   acc_ff [ROWS];
   logic [AccW-1:0]   acc_in [ROWS];
   logic [DEPTH-1:0]  gain_ok_ff, gain_ok_in;

   logic              issue;
   logic              clear_all;
   logic              ram_we;
   logic [AW-1:0]     waddr;
   logic [AW-1:0]     raddr;
   logic [GW-1:0]     ram_rdata;
   logic signed [GW-1:0] gain_sel;
   logic [AccW-1:0]   acc_sel;
   logic [AccW-1:0]   rnd_sum;
   logic [RW-1:0]     rnd;
   logic              clip_now;
   logic [SW-1:0]     sat_val;
   logic [CH_W-1:0]   last_wr;
   logic              out_free;

   assign waddr = AW'(int'(q_item.row) * COLS + int'(q_item.col));
   assign raddr = AW'(int'(o_ff) * COLS + int'(cur_ff.col));

   crm_ram #(
      .WIDTH(GW),
      .DEPTH(DEPTH)
   ) u_gain_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(waddr),
      .wdata(q_item.gain),
      .raddr(raddr),
      .rdata(ram_rdata)
   );

   // configuration
   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (csr_ch.active_outputs == '0) begin
         last_wr = '0;
      end else if (int'(csr_ch.active_outputs) > ROWS) begin
         last_wr = CH_W'(ROWS - 1);
      end else begin
         last_wr = CH_W'(csr_ch.active_outputs - 1'b1);
      end
   end

   // frame finish: round half away from zero, drop fraction, saturate
   assign acc_sel = acc_ff[o_ff[IDX_W-1:0]];
   assign rnd_sum = mag_ff + ROUND_HALF;
   assign rnd     = rnd_sum[AccW-1:FW];

   always_comb begin
      if (!neg_ff) begin
         clip_now = rnd > POS_LIM;
         sat_val  = clip_now ? SW'(32'h7FFF_FFFF) : rnd[SW-1:0];
      end else begin
         clip_now = rnd > NEG_LIM;
         sat_val  = clip_now ? SW'(32'h8000_0000) : SW'(0) - rnd[SW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      o_in          = o_ff;
      last_in       = last_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      issue         = 1'b0;
      clear_all     = 1'b0;

      if (csr_ch.valid) begin
         last_in = last_wr;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               o_in   = '0;
               case (q_item.kind)
                  crm_pkg::KIND_GAIN_WRITE: ram_we = 1'b1;
                  crm_pkg::KIND_MIX:        state_in = ST_MIX;
                  crm_pkg::KIND_SKIP:       state_in = ST_FIN_MAG;
                  default:                  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MIX: begin
            issue = 1'b1;
            if (o_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               o_in = o_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               o_in     = '0;
               state_in = cur_ff.frame_end ? ST_FIN_MAG : ST_IDLE;
            end
         end
         ST_FIN_MAG: begin
            neg_in   = acc_sel[AccW-1];
            mag_in   = acc_sel[AccW-1] ? AccW'(0) - acc_sel : acc_sel;
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (out_free) begin
               if (clip_now && clip_ff != '1) begin
                  clip_in = clip_ff + 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_index_in  = o_ff;
               rsp_sample_in = sat_val;
               rsp_clip_in   = clip_now;
               rsp_total_in  = (clip_now && clip_ff != '1) ? clip_ff + 1'b1 : clip_ff;
               rsp_last_in   = o_ff == last_ff;
               if (o_ff == last_ff) begin
                  clear_all = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  o_in     = o_ff + 1'b1;
                  state_in = ST_FIN_MAG;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         o_ff         <= '0;
         last_ff      <= '0;
         clip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         o_ff         <= o_in;
         last_ff      <= last_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_index     = rsp_index_ff;
   assign rsp_ch.sample_out    = rsp_sample_ff;
   assign rsp_ch.was_clipped   = rsp_clip_ff;
   assign rsp_ch.clip_total    = rsp_total_ff;
   assign rsp_ch.last_of_frame = rsp_last_ff;

   // mix pipeline: gain read, multiply, accumulate
   assign gain_sel = rd_ok_ff ? $signed(ram_rdata) : '0;
   assign prod_in  = gain_sel * $signed(cur_ff.sample);

   always_comb begin
      rd_v_in     = issue;
      rd_idx_in   = o_ff[IDX_W-1:0];
      rd_ok_in    = gain_ok_ff[raddr];
      prod_v_in   = rd_v_ff;
      prod_idx_in = rd_idx_ff;
      gain_ok_in  = gain_ok_ff;
      if (ram_we) begin
         gain_ok_in[waddr] = 1'b1;
      end
      for (int i = 0; i < ROWS; i++) begin
         if (clear_all) begin
            acc_in[i] = '0;
         end else if (prod_v_ff && int'(prod_idx_ff) == i) begin
            acc_in[i] = acc_ff[i] + {{(AccW - PW){prod_ff[PW-1]}}, prod_ff};
         end else begin
            acc_in[i] = acc_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff    <= 1'b0;
         prod_v_ff  <= 1'b0;
         gain_ok_ff <= '0;
         for (int i = 0; i < ROWS; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         rd_v_ff    <= rd_v_in;
         prod_v_ff  <= prod_v_in;
         gain_ok_ff <= gain_ok_in;
         for (int i = 0; i < ROWS; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
      rd_idx_ff   <= rd_idx_in;
      rd_ok_ff    <= rd_ok_in;
      prod_idx_ff <= prod_idx_in;
      prod_ff     <= prod_in;
   end

endmodule

// ===== design/channel_remix_matrix_core.sv =====
// Channel remix matrix: mixes input channel samples into up to eight output channels.
// req_ch carries one word per gain write (func = 1, at out_channel/in_channel) or per
// input sample (func = 0); frame_end on a sample word closes the frame. csr_ch writes
// active_outputs (n) only while the block is idle, a user rule not enforced by the block.
// rsp_ch returns n words per closed frame, out_index 0 .. n-1, last_of_frame on the last.
// Words enter a two-word queue; a sequencer behind it works one word at a time:
//   gain write       written into the gain table
//   sample           one gain read per output from the dual-port
//                    table, then the shared multiplier and accumulator pipeline drains
//   frame end        per output: magnitude, then round and saturate
// csr_ch is always ready; n = 0 acts as 1, and n above the output count as that count.
// Reset (synchronous) zeroes the gain table at once through per-entry valid bits,
// clears accumulators and the clip count, and sets n to 1; no clearing pass.
// When rsp_ch stalls, the result register holds and the sequencer waits; the queue
// keeps taking words until full, then req_ch.ready drops.
module channel_remix_matrix_core #(
   parameter int MAX_OUTPUTS = crm_pkg::MAX_OUTPUTS_DEF,
   parameter int MAX_INPUTS  = crm_pkg::MAX_INPUTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   crm_req_if.sink   req_ch,
   crm_rsp_if.source rsp_ch,
   crm_csr_if.sink   csr_ch
);

   logic              q_valid;
   logic              q_pop;
   crm_pkg::item_type q_item;

   crm_front #(
      .MAX_OUTPUTS(MAX_OUTPUTS),
      .MAX_INPUTS (MAX_INPUTS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop)
   );

   crm_back #(
      .MAX_OUTPUTS(MAX_OUTPUTS),
      .MAX_INPUTS (MAX_INPUTS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop),
      .csr_ch (csr_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== design/crm_checker.sv =====
module crm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [crm_pkg::CH_W-1:0]    out_index,
   input logic [crm_pkg::SAMPLE_W-1:0] sample_out,
   input logic                        was_clipped,
   input logic [crm_pkg::CNT_W-1:0]   clip_total,
   input logic                        last_of_frame
);

   logic [crm_pkg::CH_W-1:0]  exp_idx_ff, exp_idx_in;
   logic [crm_pkg::CNT_W-1:0] prev_clip_ff, prev_clip_in;
   logic                      taken;

   assign taken = rsp_valid && rsp_ready;

   always_comb begin
      exp_idx_in   = exp_idx_ff;
      prev_clip_in = prev_clip_ff;
      if (taken) begin
         exp_idx_in   = last_of_frame ? '0 : out_index + 1'b1;
         prev_clip_in = clip_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff   <= '0;
         prev_clip_ff <= '0;
      end else begin
         exp_idx_ff   <= exp_idx_in;
         prev_clip_ff <= prev_clip_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out) && $stable(out_index))
      else $error("result word changed while stalled");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_index == exp_idx_ff)
      else $error("output index out of sequence");

   a_clip_step: assert property (@(posedge clock) disable iff (reset)
      taken && was_clipped && prev_clip_ff != '1 |-> clip_total == prev_clip_ff + 1'b1)
      else $error("clip count did not advance on a clipped word");

   a_clip_hold: assert property (@(posedge clock) disable iff (reset)
      taken && !was_clipped |-> clip_total == prev_clip_ff)
      else $error("clip count moved without clipping");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_clipped |->
         sample_out == 32'h7FFF_FFFF || sample_out == 32'h8000_0000)
      else $error("clipped word not at a rail");

endmodule

bind channel_remix_matrix_core crm_checker u_crm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_index    (rsp_ch.out_index),
   .sample_out   (rsp_ch.sample_out),
   .was_clipped  (rsp_ch.was_clipped),
   .clip_total   (rsp_ch.clip_total),
   .last_of_frame(rsp_ch.last_of_frame)
);

// ===== verif/crm_mix_checker.sv =====
`timescale 1ns / 100ps

module crm_mix_checker (
   input  logic clock,
   input  logic reset,
   crm_req_if   req_ch,
   crm_rsp_if   rsp_ch,
   crm_csr_if   csr_ch,
   output int   fail_count,
   output int   words_checked,
   output int   words_due
);
   import crm_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0]     idx;
      logic [SAMPLE_W-1:0] value;
      logic                clipped;
      logic [CNT_W-1:0]    total;
      logic                last;
   } mix_out_type;

   logic signed [GAIN_W-1:0] gains [MAX_OUTPUTS_DEF][MAX_INPUTS_DEF];
   logic [ACC_W-1:0]         sums [MAX_OUTPUTS_DEF];
   logic [CNT_W-1:0]         clip_cnt;
   logic [ACT_W-1:0]         width_reg;
   mix_out_type              mixed_due [$];

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // round half away from zero, drop the fraction, saturate to 32 bits
   function automatic logic [SAMPLE_W-1:0] scale_out(input logic [ACC_W-1:0] acc,
                                                     output logic clipped);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] r;
      mag = acc[ACC_W-1] ? -acc : acc;
      r = (mag + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      clipped = 1'b0;
      if (!acc[ACC_W-1]) begin
         if (r > 64'h7FFF_FFFF) begin
            clipped = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return r[SAMPLE_W-1:0];
      end
      if (r > 64'h8000_0000) begin
         clipped = 1'b1;
         return 32'h8000_0000;
      end
      return -r[SAMPLE_W-1:0];
   endfunction

   task automatic take_word();
      int          n;
      longint      prod;
      mix_out_type w;
      logic        c;
      n = (width_reg == 0) ? 1 :
          ((width_reg > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF : int'(width_reg));
      if (req_ch.func) begin
         gains[req_ch.out_channel][req_ch.in_channel] = req_ch.gain_value;
         return;
      end
      for (int o = 0; o < n; o++) begin
         prod = longint'(gains[o][req_ch.in_channel]) * longint'(req_ch.sample_in);
         sums[o] = sums[o] + prod;
      end
      if (!req_ch.frame_end) begin
         return;
      end
      for (int o = 0; o < n; o++) begin
         w.value = scale_out(sums[o], c);
         if (c && clip_cnt != '1) begin
            clip_cnt++;
         end
         w.idx     = CH_W'(o);
         w.clipped = c;
         w.total   = clip_cnt;
         w.last    = (o == n - 1);
         mixed_due.push_back(w);
      end
      foreach (sums[k]) begin
         sums[k] = '0;
      end
   endtask

   task automatic check_word();
      mix_out_type w;
      words_checked++;
      if (mixed_due.size() == 0) begin
         report($sformatf("result word out_index %0d with nothing expected", rsp_ch.out_index));
         return;
      end
      w = mixed_due.pop_front();
      if (rsp_ch.out_index !== w.idx) begin
         report($sformatf("out_index %0d, expected %0d", rsp_ch.out_index, w.idx));
      end
      if (rsp_ch.sample_out !== w.value) begin
         report($sformatf("out %0d sample_out %0d, expected %0d", w.idx, rsp_ch.sample_out,
                          $signed(w.value)));
      end
      if (rsp_ch.was_clipped !== w.clipped) begin
         report($sformatf("out %0d was_clipped %b, expected %b", w.idx, rsp_ch.was_clipped,
                          w.clipped));
      end
      if (rsp_ch.clip_total !== w.total) begin
         report($sformatf("out %0d clip_total %0d, expected %0d", w.idx, rsp_ch.clip_total,
                          w.total));
      end
      if (rsp_ch.last_of_frame !== w.last) begin
         report($sformatf("out %0d last_of_frame %b, expected %b", w.idx, rsp_ch.last_of_frame,
                          w.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (gains[r, c]) begin
            gains[r][c] = '0;
         end
         foreach (sums[k]) begin
            sums[k] = '0;
         end
         clip_cnt  = '0;
         width_reg = ACT_W'(1);
         mixed_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            width_reg = csr_ch.active_outputs;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_word();
         end
         if (req_ch.valid && req_ch.ready) begin
            take_word();
         end
      end
      words_due = mixed_due.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import crm_pkg::*;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_GAIN   = 1'b1;

   localparam logic signed [GAIN_W-1:0]   GAIN_TOP      = 25'sh0FF_FFFF;
   localparam logic signed [GAIN_W-1:0]   GAIN_BOTTOM   = 25'sh100_0000;
   localparam logic signed [GAIN_W-1:0]   GAIN_UNITY    = 25'sh010_0000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HALF   = 32'sh0008_0000;
   localparam int DRAIN_CYCLES = 40;
   localparam int CHOKE_CYCLES = 400;
   localparam int WRAP_LEN     = 258;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_checked;
   int   words_due;
   int   words_sent;
   int   frames_sent;
   bit   tx_calm;
   bit   rx_calm;
   bit   choke;
   int   width_plan [11] = '{8, 0, 3, 15, 5, 9, 2, 7, 1, 4, 6};

   crm_req_if req_ch ();
   crm_rsp_if rsp_ch ();
   crm_csr_if csr_ch ();

   channel_remix_matrix_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   crm_mix_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .words_due     (words_due)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return SAMPLE_TOP;
         1: return SAMPLE_BOTTOM;
         2: return SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return GAIN_TOP;
         1: return GAIN_BOTTOM;
         2: return GAIN_W'(int'($urandom_range(0, 64)) - 32);
         3: return '0;
         4, 5: return GAIN_W'(int'($urandom_range(0, 2097152)) - 1048576);
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [CH_W-1:0] pick_ch();
      return CH_W'($urandom_range(0, 7));
   endfunction

   task automatic send_word(input logic f, input logic [CH_W-1:0] ich,
                            input logic [CH_W-1:0] och, input logic signed [SAMPLE_W-1:0] smp,
                            input logic signed [GAIN_W-1:0] g, input logic fe);
      int gap;
      if ($urandom_range(0, 23) == 0) begin
         tx_calm = !tx_calm;
      end
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.in_channel  <= ich;
      req_ch.out_channel <= och;
      req_ch.sample_in   <= smp;
      req_ch.gain_value  <= g;
      req_ch.frame_end   <= fe;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (f == FUNC_SAMPLE && fe) begin
         frames_sent++;
      end
   endtask

   task automatic set_width(input int v);
      csr_ch.valid          <= 1'b1;
      csr_ch.active_outputs <= ACT_W'(v);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // block must be idle before a register write
   task automatic settle();
      req_ch.valid <= 1'b0;
      forever begin
         @(negedge clock);
         if (words_due == 0) break;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_frame();
      int len;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            send_word(FUNC_GAIN, pick_ch(), pick_ch(), $urandom,
                      pick_gain(), $urandom_range(0, 7) == 0);
         end
      end
      len = $urandom_range(1, 10);
      for (int k = 1; k <= len; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_word(FUNC_GAIN, pick_ch(), pick_ch(), $urandom,
                      pick_gain(), 1'b0);
         end
         send_word(FUNC_SAMPLE, pick_ch(), pick_ch(), pick_sample(),
                   GAIN_W'($urandom), k == len);
      end
   endtask

   // receiver: random stalls, calm stretches, and one long hold-off
   initial begin
      int stall;
      bit choke_done;
      choke_done = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 23) == 0) begin
            rx_calm = !rx_calm;
         end
         stall = rx_calm ? 0 : $urandom_range(0, 18);
         if (choke && !choke_done) begin
            stall = CHOKE_CYCLES;
            choke_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      int mark;
      int wait_cnt;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.func           = FUNC_SAMPLE;
      req_ch.in_channel     = '0;
      req_ch.out_channel    = '0;
      req_ch.sample_in      = '0;
      req_ch.gain_value     = '0;
      req_ch.frame_end      = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.active_outputs = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one output after reset: cleared table, rounding at the half step
      send_word(FUNC_SAMPLE, 3'd0, 3'd0, SAMPLE_TOP, GAIN_TOP, 1'b1);
      send_word(FUNC_GAIN, 3'd0, 3'd0, SAMPLE_BOTTOM, 25'sd1, 1'b1);
      send_word(FUNC_SAMPLE, 3'd0, 3'd0, SAMPLE_HALF, '0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd0, 3'd0, -SAMPLE_HALF, '0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd0, 3'd0, SAMPLE_HALF - 1, '0, 1'b1);
      settle();

      // all eight outputs: saturation edges, both signs
      set_width(8);
      send_word(FUNC_GAIN, 3'd0, 3'd0, '0, GAIN_UNITY, 1'b0);
      send_word(FUNC_GAIN, 3'd0, 3'd1, '0, -GAIN_UNITY, 1'b0);
      send_word(FUNC_GAIN, 3'd0, 3'd2, '0, GAIN_TOP, 1'b0);
      send_word(FUNC_GAIN, 3'd0, 3'd3, '0, GAIN_BOTTOM, 1'b0);
      send_word(FUNC_GAIN, 3'd1, 3'd4, '0, GAIN_UNITY, 1'b0);
      send_word(FUNC_GAIN, 3'd0, 3'd5, '0, 25'sd1, 1'b0);
      send_word(FUNC_GAIN, 3'd0, 3'd6, '0, -25'sd1, 1'b0);
      send_word(FUNC_GAIN, 3'd7, 3'd7, '0, GAIN_TOP, 1'b0);
      send_word(FUNC_SAMPLE, 3'd0, 3'd7, SAMPLE_BOTTOM, GAIN_TOP, 1'b0);
      send_word(FUNC_SAMPLE, 3'd1, 3'd0, SAMPLE_TOP, GAIN_BOTTOM, 1'b1);
      send_word(FUNC_SAMPLE, 3'd7, 3'd0, SAMPLE_TOP, '0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd7, 3'd0, SAMPLE_BOTTOM, '0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd1, 3'd0, SAMPLE_TOP, '0, 1'b0);
      send_word(FUNC_SAMPLE, 3'd1, 3'd0, SAMPLE_TOP, '0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd6, 3'd3, SAMPLE_TOP, GAIN_TOP, 1'b1);
      settle();

      foreach (width_plan[p]) begin
         set_width(width_plan[p]);
         if (p == 0) begin
            tx_calm = 1'b1;
            choke <= 1'b1;
         end
         mark = words_sent;
         while (words_sent - mark < ((p == 0) ? 20 : 4)) random_frame();
         settle();
      end

      // long frame: accumulator wraps past the signed 64-bit top
      set_width(1);
      send_word(FUNC_GAIN, 3'd2, 3'd0, '0, GAIN_BOTTOM, 1'b0);
      for (int k = 1; k <= WRAP_LEN; k++) begin
         send_word(FUNC_SAMPLE, 3'd2, 3'd0, SAMPLE_BOTTOM, '0, k == WRAP_LEN);
      end

      req_ch.valid <= 1'b0;
      wait_cnt = 0;
      while (words_due != 0 && wait_cnt < 20000) begin
         @(negedge clock);
         wait_cnt++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words closing %0d frames, checked %0d mixed words,",
               words_sent, frames_sent, words_checked);
      $display("over %0d output widths incl. 0 and 15, a 400-cycle output stall, a wrap frame.",
               $size(width_plan) + 3);
      if (fail_count == 0 && words_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
